// ----- rtl/core/dhkt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package dhkt_pkg;
	localparam int MAX_SLOTS_DEF  = 1024;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 32;

	localparam int SIZE_W   = 10;
	localparam int KEY_W    = 64;
	localparam int DIVD_W   = 12;
	localparam int CNT_W    = 4;
	localparam int SIZE_MIN = 3;
	localparam int SIZE_RST = 1021;
	localparam int HASH_ADD = 33;

	localparam logic [1:0] H_FIND   = 2'd0;
	localparam logic [1:0] H_ENTER  = 2'd1;
	localparam logic [1:0] H_DELETE = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_EMPTY_KEY   = 3'd3;
	localparam logic [2:0] ST_PROBE_LIMIT = 3'd4;
endpackage
`default_nettype wire

// ----- rtl/core/dhkt_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dhkt_mod (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [dhkt_pkg::DIVD_W-1:0]    dividend,
	input  wire logic [dhkt_pkg::SIZE_W-1:0]    divisor,
	output logic                                done,
	output logic [dhkt_pkg::SIZE_W-1:0]         rem
);
	logic                          run_q;
	logic                          done_q;
	logic [dhkt_pkg::CNT_W-1:0]    cnt_q;
	logic [dhkt_pkg::DIVD_W-1:0]   n_q;
	logic [dhkt_pkg::SIZE_W-1:0]   d_q;
	logic [dhkt_pkg::SIZE_W-1:0]   r_q;
	logic [dhkt_pkg::SIZE_W:0]     shifted;
	logic [dhkt_pkg::SIZE_W:0]     r_next;

	// one restoring remainder step per cycle
	always_comb begin
		shifted = {r_q, n_q[dhkt_pkg::DIVD_W-1]};
		if (shifted >= {1'b0, d_q}) begin
			r_next = shifted - {1'b0, d_q};
		end else begin
			r_next = shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= dhkt_pkg::CNT_W'(dhkt_pkg::DIVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dhkt_pkg::CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (run_q) begin
			n_q <= n_q << 1;
			r_q <= r_next[dhkt_pkg::SIZE_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;
endmodule
`default_nettype wire

// ----- rtl/core/dhkt_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dhkt_mem #(
	parameter int DEPTH = dhkt_pkg::MAX_SLOTS_DEF + 1,
	parameter int IW    = $clog2(dhkt_pkg::MAX_SLOTS_DEF + 1),
	parameter int VB    = dhkt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [IW-1:0]                 addr,
	input  wire logic [dhkt_pkg::SIZE_W-1:0]   wtag,
	input  wire logic                          wlive,
	input  wire logic [dhkt_pkg::KEY_W-1:0]    wkey,
	input  wire logic [VB-1:0]                 wval,
	output logic [dhkt_pkg::SIZE_W-1:0]        rtag,
	output logic                               rlive,
	output logic [dhkt_pkg::KEY_W-1:0]         rkey,
	output logic [VB-1:0]                      rval
);
	localparam int WW = dhkt_pkg::SIZE_W + 1 + dhkt_pkg::KEY_W + VB;

	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= {wtag, wlive, wkey, wval};
		end
		rd_q <= mem[addr];
	end

	assign {rtag, rlive, rkey, rval} = rd_q;
endmodule
`default_nettype wire

// ----- rtl/core/double_hash_key_table.sv -----
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+--------------------------
// request   | func, key, value_in                     | start, taken when !busy
// result    | status, found_value, live_entries       | done, one cycle, no stall
// config    | cfg_wdata                               | cfg_we, taken at once
//
// after reset a clearing pass writes all MAX_SLOTS+1 slots, one per cycle, busy high
// two remainder passes on the shared divider, each of 12 steps followed by its done cycle,
// then each probe visits S_RD (slot read) and S_EV (compare) until the probe ends
// rejected enters and unknown codes raise done at the accepting edge itself
// results cannot be held off by the receiver
`timescale 1ns / 1ps
`default_nettype none
module double_hash_key_table #(
	parameter int MAX_SLOTS  = dhkt_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BYTES  = dhkt_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = dhkt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [dhkt_pkg::SIZE_W-1:0]  cfg_wdata,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   func,
	input  wire logic [dhkt_pkg::KEY_W-1:0]   key,
	input  wire logic [31:0]                  value_in,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [31:0]                       found_value,
	output logic [dhkt_pkg::SIZE_W-1:0]       live_entries
);
	localparam int IW       = $clog2(MAX_SLOTS + 1);
	localparam int MaxUsed  = MAX_SLOTS - 3;
	localparam int SizeRst  = (dhkt_pkg::SIZE_RST > MaxUsed) ? MaxUsed : dhkt_pkg::SIZE_RST;
	localparam int SW       = dhkt_pkg::SIZE_W;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_H1   = 3'd2;
	localparam logic [2:0] S_H2   = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_EV   = 3'd5;

	logic [2:0]                       state_q;
	logic [IW-1:0]                    clr_q;
	logic [SW-1:0]                    size_q;
	logic [SW-1:0]                    live_q;
	logic [1:0]                       func_q;
	logic [dhkt_pkg::KEY_W-1:0]       nk_q;
	logic [VALUE_BITS-1:0]            val_q;
	logic [SW-1:0]                    hval_q;
	logic [SW-1:0]                    hval2_q;
	logic [IW-1:0]                    idx_q;
	logic [SW-1:0]                    steps_q;
	logic                             done_q;
	logic [2:0]                       status_q;
	logic [31:0]                      found_q;
	logic [SW-1:0]                    live_out_q;

	logic [dhkt_pkg::KEY_W-1:0]       nk;
	logic [dhkt_pkg::DIVD_W-1:0]      sum;
	logic                             alive;
	logic                             accept;
	logic                             early;
	logic [2:0]                       early_st;
	logic                             mod_start;
	logic [dhkt_pkg::DIVD_W-1:0]      mod_n;
	logic [SW-1:0]                    mod_d;
	logic                             mod_done;
	logic [SW-1:0]                    mod_rem;
	logic [SW-1:0]                    h1;

	logic                             we;
	logic [IW-1:0]                    maddr;
	logic [SW-1:0]                    wtag;
	logic                             wlive;
	logic [dhkt_pkg::KEY_W-1:0]       wkey;
	logic [VALUE_BITS-1:0]            wval;
	logic [SW-1:0]                    rtag;
	logic                             rlive;
	logic [dhkt_pkg::KEY_W-1:0]       rkey;
	logic [VALUE_BITS-1:0]            rval;

	logic                             ev_end;
	logic [2:0]                       ev_st;
	logic [31:0]                      ev_found;
	logic [SW-1:0]                    ev_live;
	logic [IW:0]                      idx_w;
	logic [IW:0]                      h2_w;
	logic [IW:0]                      idx_next;

	// key bytes up to the first zero byte, at most KEY_BYTES of them
	always_comb begin
		nk    = '0;
		sum   = '0;
		alive = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (i < KEY_BYTES && alive && key[8*i +: 8] != 8'd0) begin
				nk[8*i +: 8] = key[8*i +: 8];
				sum          = sum + dhkt_pkg::DIVD_W'(key[8*i +: 8]);
			end else begin
				alive = 1'b0;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		early    = 1'b0;
		early_st = dhkt_pkg::ST_OK;
		priority if (func != dhkt_pkg::H_FIND && func != dhkt_pkg::H_ENTER &&
				func != dhkt_pkg::H_DELETE) begin
			early    = 1'b1;
			early_st = dhkt_pkg::ST_NOT_FOUND;
		end else if (func == dhkt_pkg::H_ENTER && key[7:0] == 8'd0) begin
			early    = 1'b1;
			early_st = dhkt_pkg::ST_EMPTY_KEY;
		end else if (func == dhkt_pkg::H_ENTER && live_q >= size_q - 1'b1) begin
			early    = 1'b1;
			early_st = dhkt_pkg::ST_FULL;
		end
	end

	assign h1 = (mod_rem == '0) ? SW'(1) : mod_rem;

	always_comb begin
		mod_start = 1'b0;
		mod_n     = dhkt_pkg::DIVD_W'(dhkt_pkg::HASH_ADD) + sum;
		mod_d     = size_q;
		if (accept && !early) begin
			mod_start = 1'b1;
		end else if (state_q == S_H1 && mod_done) begin
			mod_start = 1'b1;
			mod_n     = dhkt_pkg::DIVD_W'(h1);
			mod_d     = size_q - SW'(2);
		end
	end

	dhkt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_n),
		.divisor  (mod_d),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// clearing writes, and the probe decision on the slot read last cycle
	always_comb begin
		ev_end   = 1'b1;
		ev_st    = dhkt_pkg::ST_OK;
		ev_found = '0;
		ev_live  = live_q;
		we       = 1'b0;
		wtag     = rtag;
		wlive    = rlive;
		wkey     = rkey;
		wval     = rval;
		idx_w    = (IW+1)'(idx_q);
		h2_w     = (IW+1)'(hval2_q);
		if (idx_w <= h2_w) begin
			idx_next = (IW+1)'(size_q) + idx_w - h2_w;
		end else begin
			idx_next = idx_w - h2_w;
		end
		if (state_q == S_CLR) begin
			we    = 1'b1;
			wtag  = '0;
			wlive = 1'b0;
		end else if (state_q == S_EV) begin
			priority if (rtag == '0) begin
				if (func_q == dhkt_pkg::H_ENTER) begin
					we      = 1'b1;
					wtag    = hval_q;
					wlive   = 1'b1;
					wkey    = nk_q;
					wval    = val_q;
					ev_live = live_q + 1'b1;
				end else begin
					ev_st = dhkt_pkg::ST_NOT_FOUND;
				end
			end else if (rtag == hval_q && !rlive && func_q == dhkt_pkg::H_ENTER) begin
				we      = 1'b1;
				wlive   = 1'b1;
				wkey    = nk_q;
				wval    = val_q;
				ev_live = live_q + 1'b1;
			end else if (rtag == hval_q && rlive && rkey == nk_q) begin
				if (func_q == dhkt_pkg::H_DELETE) begin
					we      = 1'b1;
					wlive   = 1'b0;
					ev_live = live_q - 1'b1;
				end else if (func_q == dhkt_pkg::H_ENTER) begin
					we   = 1'b1;
					wval = val_q;
				end else begin
					ev_found = 32'(rval);
				end
			end else if (steps_q >= size_q) begin
				ev_st = dhkt_pkg::ST_PROBE_LIMIT;
			end else begin
				ev_end = 1'b0;
			end
		end
	end

	assign maddr = (state_q == S_CLR) ? clr_q : idx_q;

	dhkt_mem #(
		.DEPTH (MAX_SLOTS + 1),
		.IW    (IW),
		.VB    (VALUE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.addr  (maddr),
		.wtag  (wtag),
		.wlive (wlive),
		.wkey  (wkey),
		.wval  (wval),
		.rtag  (rtag),
		.rlive (rlive),
		.rkey  (rkey),
		.rval  (rval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			size_q  <= SW'(SizeRst);
			live_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_wdata < SW'(dhkt_pkg::SIZE_MIN)) begin
					size_q <= SW'(dhkt_pkg::SIZE_MIN);
				end else if (int'(cfg_wdata) > MaxUsed) begin
					size_q <= SW'(MaxUsed);
				end else begin
					size_q <= cfg_wdata;
				end
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(MAX_SLOTS)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (early) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_H1;
						end
					end
				end
				S_H1: begin
					if (mod_done) begin
						state_q <= S_H2;
					end
				end
				S_H2: begin
					if (mod_done) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (ev_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						live_q  <= ev_live;
					end else begin
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func;
			nk_q       <= nk;
			val_q      <= VALUE_BITS'(value_in);
			status_q   <= early_st;
			found_q    <= '0;
			live_out_q <= live_q;
		end
		if (state_q == S_H1 && mod_done) begin
			hval_q <= h1;
		end
		if (state_q == S_H2 && mod_done) begin
			hval2_q <= mod_rem + 1'b1;
			idx_q   <= IW'(hval_q);
			steps_q <= '0;
		end
		if (state_q == S_EV) begin
			if (ev_end) begin
				status_q   <= ev_st;
				found_q    <= ev_found;
				live_out_q <= ev_live;
			end else begin
				idx_q   <= idx_next[IW-1:0];
				steps_q <= steps_q + 1'b1;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found_value  = found_q;
	assign live_entries = live_out_q;
endmodule
`default_nettype wire

// ----- rtl/core/dhkt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module dhkt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [31:0] found_value
);
	a_accept_reacts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted word neither answered nor busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= dhkt_pkg::ST_PROBE_LIMIT))
		else $error("bad status code");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != dhkt_pkg::ST_OK) |-> (found_value == 32'd0))
		else $error("value on failed request");
endmodule

bind double_hash_key_table dhkt_checker u_dhkt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_value (found_value)
);
`default_nettype wire
